// File: sv/tlbs_pkg.sv
// ----------------------------------------------------------------------------
// Linear triangle basis setup: shared types and constants
// Widths of the coefficient datapath and the words passed between the parts.
// ----------------------------------------------------------------------------
package tlbs_pkg;

    // Nine coefficients per triangle: const, dr, dz for each of three vertices.
    localparam int NUM_COEF = 9;
    // Quotient width (signed Q16.32 result).
    localparam int QW = 48;
    // Numerator magnitude width after the fractional shift.
    localparam int NW = 96;
    // Magnitude width of twice the signed area.
    localparam int DW = 66;
    // Width of the degenerate-limit register.
    localparam int TW = 63;
    // Saturation limits as magnitudes.
    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    // Word handed from the setup front to the divider back.
    typedef struct packed {
        logic                            valid_res;
        logic                            dneg;
        logic [DW-1:0]                   dmag;
        logic [NUM_COEF-1:0]             nneg;
        logic [NUM_COEF-1:0][NW-1:0]     nmag;
    } setup_t;

    // Word held in the result queue.
    typedef struct packed {
        logic                            valid_res;
        logic [NUM_COEF-1:0][QW-1:0]     coef;
    } result_t;

endpackage

// File: sv/tlbs_front.sv
// ----------------------------------------------------------------------------
// Triangle setup front
// Four-stage pipeline: edge differences, products, area and cofactors, then
// magnitudes, signs and the degenerate test.
// ----------------------------------------------------------------------------
module tlbs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [31:0]          r0,
    input  logic signed [31:0]          z0,
    input  logic signed [31:0]          r1,
    input  logic signed [31:0]          z1,
    input  logic signed [31:0]          r2,
    input  logic signed [31:0]          z2,
    input  logic [tlbs_pkg::TW-1:0]     det_threshold,
    output logic                        out_valid,
    output tlbs_pkg::setup_t            out_setup
);

    // Stage 1 registers.
    logic                v1_reg;
    logic signed [31:0]  r_s1_reg [3];
    logic signed [31:0]  z_s1_reg [3];
    logic signed [32:0]  dr1_reg, dz2_reg, dr2_reg, dz1_reg;
    logic signed [32:0]  gr_s1_reg [3];
    logic signed [32:0]  gz_s1_reg [3];

    // Stage 2 registers.
    logic                v2_reg;
    logic signed [65:0]  pda_reg, pdb_reg;
    logic signed [63:0]  pca_reg [3];
    logic signed [63:0]  pcb_reg [3];
    logic signed [32:0]  gr_s2_reg [3];
    logic signed [32:0]  gz_s2_reg [3];

    // Stage 3 registers.
    logic                v3_reg;
    logic signed [66:0]  det_reg;
    logic signed [64:0]  cof_reg [3];
    logic signed [32:0]  gr_s3_reg [3];
    logic signed [32:0]  gz_s3_reg [3];

    // Stage 4 register.
    logic                v4_reg;
    tlbs_pkg::setup_t    setup_reg;

    // Sign-extended coordinates for the edge differences.
    logic signed [32:0]  r0x, z0x, r1x, z1x, r2x, z2x;
    // Magnitude and sign logic of stage 4.
    logic [66:0]         det_mag;
    logic [64:0]         cof_mag [3];
    logic [32:0]         gr_mag [3];
    logic [32:0]         gz_mag [3];
    tlbs_pkg::setup_t    setup_next;

    assign r0x = {r0[31], r0};
    assign z0x = {z0[31], z0};
    assign r1x = {r1[31], r1};
    assign z1x = {z1[31], z1};
    assign r2x = {r2[31], r2};
    assign z2x = {z2[31], z2};

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: edge differences and gradient numerators.
    always_ff @(posedge clk)
    begin
        r_s1_reg[0] <= r0;
        r_s1_reg[1] <= r1;
        r_s1_reg[2] <= r2;
        z_s1_reg[0] <= z0;
        z_s1_reg[1] <= z1;
        z_s1_reg[2] <= z2;
        dr1_reg <= r1x - r0x;
        dz2_reg <= z2x - z0x;
        dr2_reg <= r2x - r0x;
        dz1_reg <= z1x - z0x;
        gr_s1_reg[0] <= z1x - z2x;
        gr_s1_reg[1] <= z2x - z0x;
        gr_s1_reg[2] <= z0x - z1x;
        gz_s1_reg[0] <= r2x - r1x;
        gz_s1_reg[1] <= r0x - r2x;
        gz_s1_reg[2] <= r1x - r0x;
    end

    // Stage 2: the two area products and the six cofactor products.
    always_ff @(posedge clk)
    begin
        pda_reg <= dr1_reg * dz2_reg;
        pdb_reg <= dr2_reg * dz1_reg;
        pca_reg[0] <= r_s1_reg[1] * z_s1_reg[2];
        pcb_reg[0] <= r_s1_reg[2] * z_s1_reg[1];
        pca_reg[1] <= r_s1_reg[2] * z_s1_reg[0];
        pcb_reg[1] <= r_s1_reg[0] * z_s1_reg[2];
        pca_reg[2] <= r_s1_reg[0] * z_s1_reg[1];
        pcb_reg[2] <= r_s1_reg[1] * z_s1_reg[0];
        gr_s2_reg <= gr_s1_reg;
        gz_s2_reg <= gz_s1_reg;
    end

    // Stage 3: twice the signed area and the constant-term cofactors.
    always_ff @(posedge clk)
    begin
        det_reg <= {pda_reg[65], pda_reg} - {pdb_reg[65], pdb_reg};
        for (int i = 0; i < 3; i++)
        begin
            cof_reg[i] <= {pca_reg[i][63], pca_reg[i]} - {pcb_reg[i][63], pcb_reg[i]};
        end
        gr_s3_reg <= gr_s2_reg;
        gz_s3_reg <= gz_s2_reg;
    end

    // Stage 4: split every value into sign and magnitude and test the area.
    always_comb
    begin
        det_mag = det_reg[66] ? 67'(-det_reg) : 67'(det_reg);
        setup_next.dneg = det_reg[66];
        setup_next.dmag = det_mag[tlbs_pkg::DW-1:0];
        setup_next.valid_res = det_mag[tlbs_pkg::DW-1:0] >
                               {{(tlbs_pkg::DW-tlbs_pkg::TW){1'b0}}, det_threshold};
        for (int i = 0; i < 3; i++)
        begin
            cof_mag[i] = cof_reg[i][64] ? 65'(-cof_reg[i]) : 65'(cof_reg[i]);
            gr_mag[i] = gr_s3_reg[i][32] ? 33'(-gr_s3_reg[i]) : 33'(gr_s3_reg[i]);
            gz_mag[i] = gz_s3_reg[i][32] ? 33'(-gz_s3_reg[i]) : 33'(gz_s3_reg[i]);
            // Constant term scaled by 2^32, gradients by 2^48.
            setup_next.nneg[3*i]   = cof_reg[i][64];
            setup_next.nmag[3*i]   = {cof_mag[i][63:0], 32'b0};
            setup_next.nneg[3*i+1] = gr_s3_reg[i][32];
            setup_next.nmag[3*i+1] = {15'b0, gr_mag[i], 48'b0};
            setup_next.nneg[3*i+2] = gz_s3_reg[i][32];
            setup_next.nmag[3*i+2] = {15'b0, gz_mag[i], 48'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        setup_reg <= setup_next;
    end

    assign out_valid = v4_reg;
    assign out_setup = setup_reg;

endmodule

// File: sv/tlbs_div_pipe.sv
// ----------------------------------------------------------------------------
// Coefficient divider pipeline
// Nine lanes of restoring division, one quotient bit per stage, with an
// overflow test on entry and saturation and sign on exit.
// ----------------------------------------------------------------------------
module tlbs_div_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  tlbs_pkg::setup_t            in_setup,
    output logic                        out_valid,
    output tlbs_pkg::result_t           out_result
);

    localparam int QW = tlbs_pkg::QW;
    localparam int DW = tlbs_pkg::DW;
    localparam int NC = tlbs_pkg::NUM_COEF;

    // Per-stage state; stage 0 is the entry load, stage QW holds all bits.
    logic                v_reg     [QW+1];
    logic                valid_reg [QW+1];
    logic                dneg_reg  [QW+1];
    logic [DW-1:0]       dmag_reg  [QW+1];
    logic [NC-1:0]       nneg_reg  [QW+1];
    logic [NC-1:0]       ovf_reg   [QW+1];
    logic [DW-1:0]       rem_reg   [QW+1][NC];
    logic [QW-1:0]       low_reg   [QW+1][NC];
    logic [QW-1:0]       q_reg     [QW+1][NC];

    logic                out_v_reg;
    tlbs_pkg::result_t   out_reg;
    tlbs_pkg::result_t   out_next;

    logic [DW:0]         trial [QW][NC];
    logic                ge    [QW][NC];
    logic [QW-1:0]       lim   [NC];
    logic [QW-1:0]       mag   [NC];
    logic                neg   [NC];

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QW; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= QW; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_v_reg <= v_reg[QW];
        end
    end

    // Entry: the upper numerator bits form the first remainder; if they
    // already reach the divisor the quotient cannot fit and saturates.
    always_ff @(posedge clk)
    begin
        valid_reg[0] <= in_setup.valid_res;
        dneg_reg[0]  <= in_setup.dneg;
        dmag_reg[0]  <= in_setup.dmag;
        nneg_reg[0]  <= in_setup.nneg;
        for (int k = 0; k < NC; k++)
        begin
            ovf_reg[0][k] <= {{(DW-(tlbs_pkg::NW-QW)){1'b0}},
                              in_setup.nmag[k][tlbs_pkg::NW-1:QW]} >= in_setup.dmag;
            rem_reg[0][k] <= {{(DW-(tlbs_pkg::NW-QW)){1'b0}},
                              in_setup.nmag[k][tlbs_pkg::NW-1:QW]};
            low_reg[0][k] <= in_setup.nmag[k][QW-1:0];
            q_reg[0][k]   <= '0;
        end
    end

    // One quotient bit per stage in every lane.
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        always_comb
        begin
            for (int k = 0; k < NC; k++)
            begin
                trial[s][k] = {rem_reg[s][k], low_reg[s][k][QW-1]};
                ge[s][k] = trial[s][k] >= {1'b0, dmag_reg[s]};
            end
        end

        always_ff @(posedge clk)
        begin
            valid_reg[s+1] <= valid_reg[s];
            dneg_reg[s+1]  <= dneg_reg[s];
            dmag_reg[s+1]  <= dmag_reg[s];
            nneg_reg[s+1]  <= nneg_reg[s];
            ovf_reg[s+1]   <= ovf_reg[s];
            for (int k = 0; k < NC; k++)
            begin
                rem_reg[s+1][k] <= ge[s][k] ? DW'(trial[s][k] - {1'b0, dmag_reg[s]})
                                            : DW'(trial[s][k]);
                low_reg[s+1][k] <= {low_reg[s][k][QW-2:0], 1'b0};
                q_reg[s+1][k]   <= {q_reg[s][k][QW-2:0], ge[s][k]};
            end
        end
    end

    // Exit: saturate, apply the sign, and zero a degenerate triangle.
    always_comb
    begin
        out_next.valid_res = valid_reg[QW];
        for (int k = 0; k < NC; k++)
        begin
            neg[k] = nneg_reg[QW][k] ^ dneg_reg[QW];
            lim[k] = neg[k] ? tlbs_pkg::SAT_NEG : tlbs_pkg::SAT_POS;
            mag[k] = (ovf_reg[QW][k] || (q_reg[QW][k] > lim[k])) ? lim[k] : q_reg[QW][k];
            if (!valid_reg[QW])
            begin
                out_next.coef[k] = '0;
            end
            else
            begin
                out_next.coef[k] = neg[k] ? QW'(-mag[k]) : mag[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid  = out_v_reg;
    assign out_result = out_reg;

endmodule

// File: sv/tlbs_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Memory-backed queue with a registered head word shown to the consumer.
// ----------------------------------------------------------------------------
module tlbs_queue #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  tlbs_pkg::result_t   wr_data,
    input  logic                pop,
    output logic                empty,
    output tlbs_pkg::result_t   head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tlbs_pkg::result_t  mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic               head_valid_reg;
    tlbs_pkg::result_t  head_reg;
    logic               load;

    // Move the oldest stored word into the head register when it frees up.
    assign load = (count_reg != '0) && (!head_valid_reg || pop);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (load)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

    // Pointers, fill count and head valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (load)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(wr_en) - CW'(load);
            if (load)
            begin
                head_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                head_valid_reg <= 1'b0;
            end
        end
    end

    assign empty = !head_valid_reg;
    assign head  = head_reg;

endmodule

// File: sv/triangle_linear_basis_setup.sv
// Throughput: one triangle per cycle while full is low; the 48-stage bit-per-stage divider
// pipeline never stalls, and the result queue depth (QUEUE_DEPTH) bounds
// the words in flight, so full rises when that many are unread.
// Reset: rst_n clears the valid bits, queue pointers and in-flight count, and
// sets det_threshold to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Linear triangle basis setup
// Computes the nine barycentric basis coefficients of a triangle in Q16.32.
// ----------------------------------------------------------------------------
module triangle_linear_basis_setup #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [31:0]          r0,
    input  logic signed [31:0]          z0,
    input  logic signed [31:0]          r1,
    input  logic signed [31:0]          z1,
    input  logic signed [31:0]          r2,
    input  logic signed [31:0]          z2,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tlbs_pkg::TW-1:0]     cfg_data,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [47:0]          c0_const,
    output logic signed [47:0]          c0_dr,
    output logic signed [47:0]          c0_dz,
    output logic signed [47:0]          c1_const,
    output logic signed [47:0]          c1_dr,
    output logic signed [47:0]          c1_dz,
    output logic signed [47:0]          c2_const,
    output logic signed [47:0]          c2_dr,
    output logic signed [47:0]          c2_dz,
    output logic                        valid_res
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [tlbs_pkg::TW-1:0]    thr_reg;
    logic [FW-1:0]              flight_reg;
    logic                       push_acc, pop_acc;
    logic                       f_valid, b_valid;
    tlbs_pkg::setup_t           f_setup;
    tlbs_pkg::result_t          b_result, head;

    assign push_acc  = push && !full;
    assign pop_acc   = pop && !empty;
    assign cfg_ready = 1'b1;

    // Degenerate limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Words in flight, counted from acceptance to delivery.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_reg + FW'(push_acc) - FW'(pop_acc);
        end
    end

    assign full = (flight_reg == FW'(QUEUE_DEPTH));

    tlbs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (push_acc),
        .r0            (r0),
        .z0            (z0),
        .r1            (r1),
        .z1            (z1),
        .r2            (r2),
        .z2            (z2),
        .det_threshold (thr_reg),
        .out_valid     (f_valid),
        .out_setup     (f_setup)
    );

    tlbs_div_pipe u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_setup   (f_setup),
        .out_valid  (b_valid),
        .out_result (b_result)
    );

    tlbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_valid),
        .wr_data (b_result),
        .pop     (pop_acc),
        .empty   (empty),
        .head    (head)
    );

    assign c0_const  = $signed(head.coef[0]);
    assign c0_dr     = $signed(head.coef[1]);
    assign c0_dz     = $signed(head.coef[2]);
    assign c1_const  = $signed(head.coef[3]);
    assign c1_dr     = $signed(head.coef[4]);
    assign c1_dz     = $signed(head.coef[5]);
    assign c2_const  = $signed(head.coef[6]);
    assign c2_dr     = $signed(head.coef[7]);
    assign c2_dz     = $signed(head.coef[8]);
    assign valid_res = head.valid_res;

endmodule

// File: sv/tlbs_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the triangle basis setup
// Watches the result side for zeroing, hold and drain behavior.
// ----------------------------------------------------------------------------
module tlbs_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop,
    input  logic                empty,
    input  logic signed [47:0]  c0_const,
    input  logic signed [47:0]  c0_dr,
    input  logic signed [47:0]  c0_dz,
    input  logic signed [47:0]  c1_const,
    input  logic signed [47:0]  c1_dr,
    input  logic signed [47:0]  c1_dz,
    input  logic signed [47:0]  c2_const,
    input  logic signed [47:0]  c2_dr,
    input  logic signed [47:0]  c2_dz,
    input  logic                valid_res
);

    // A degenerate triangle shows all coefficients as zero.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !valid_res) |-> (c0_const == 0 && c0_dr == 0 && c0_dz == 0 &&
            c1_const == 0 && c1_dr == 0 && c1_dz == 0 &&
            c2_const == 0 && c2_dr == 0 && c2_dz == 0))
        else $error("degenerate result with nonzero coefficient");

    // A waiting word stays put until it is taken; valid_res, c0_const, c1_dr and c2_dz are compared.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(valid_res) && $stable(c0_const) &&
            $stable(c1_dr) && $stable(c2_dz)))
        else $error("result word changed while stalled");

    // The queue only drains through a pop.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result vanished without a pop");

endmodule

bind triangle_linear_basis_setup tlbs_checker u_tlbs_checker (.*);
